// ===== src/fts_pkg.sv =====
// Shared constants, codes and types of the fixed-time signal controller.
// Has no dependencies; every other file of the block but fts_ram imports it.
`timescale 1ns / 1ps

package fts_pkg;

    // Table size and time width.
    localparam int STREETS   = 16;
    localparam int NDIR      = 7;
    localparam int SLOTS     = STREETS * NDIR;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int TIME_BITS = 16;
    localparam int CNT_W     = $clog2(TIME_BITS + 2);

    // Item field widths.
    localparam int ACT_W    = 3;
    localparam int STREET_W = 4;
    localparam int DIR_W    = 3;
    localparam int STAT_W   = 3;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = TIME_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_TURNS = 1'b1;
    localparam logic [TIME_BITS-1:0] CYCLE_TIME_RESET = TIME_BITS'(60);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK,
        ACT_LOAD,
        ACT_QUERY,
        ACT_COMPLEMENT,
        ACT_SHIFT
    } t_action;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_ANY            = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT          = 3'd1;
    localparam logic [DIR_W-1:0] DIR_STRAIGHT       = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT           = 3'd3;
    localparam logic [DIR_W-1:0] DIR_UTURN          = 3'd4;
    localparam logic [DIR_W-1:0] DIR_RIGHT_STRAIGHT = 3'd5;
    localparam logic [DIR_W-1:0] DIR_LEFT_STRAIGHT  = 3'd6;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK             = 3'd0;
    localparam logic [STAT_W-1:0] STAT_GREEN_TOO_LONG = 3'd1;
    localparam logic [STAT_W-1:0] STAT_PHASE_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_STREET_BUSY    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SOURCE_EMPTY   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN_STREET = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICK_WAIT,
        ST_Q_START,
        ST_Q_WAIT_S,
        ST_Q_WAIT_E,
        ST_C_READ,
        ST_C_CALC,
        ST_C_WAIT,
        ST_S_READ,
        ST_S_CALC,
        ST_S_WAIT,
        ST_FINISH
    } t_state;

    // Table slot of a street and direction: street * 7 + direction.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [STREET_W-1:0] s,
                                                  input logic [DIR_W-1:0] d);
        logic [STREET_W+DIR_W:0] tmp;
        tmp = {1'b0, s, 3'b000} - {4'b0000, s} + {5'b00000, d};
        return SLOT_W'(tmp);
    endfunction

endpackage

// ===== src/fts_in_if.sv =====
// Input item channel of the fixed-time signal controller.
// Depends on fts_pkg for the field widths.
`timescale 1ns / 1ps

interface fts_in_if;
    import fts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [STREET_W-1:0]   street;
    logic [DIR_W-1:0]      direction;
    logic [TIME_BITS-1:0]  green_time;
    logic [TIME_BITS-1:0]  phase;
    logic [STREET_W-1:0]   source_street;
    logic [TIME_BITS-1:0]  phase_shift;

    modport source (
        output valid, action, street, direction, green_time, phase,
               source_street, phase_shift,
        input  ready
    );
    modport sink (
        input  valid, action, street, direction, green_time, phase,
               source_street, phase_shift,
        output ready
    );
endinterface

// ===== src/fts_out_if.sv =====
// Result item channel of the fixed-time signal controller.
// Depends on fts_pkg for the field widths.
`timescale 1ns / 1ps

interface fts_out_if;
    import fts_pkg::*;

    logic              valid;
    logic              ready;
    logic              green;
    logic [STAT_W-1:0] status;

    modport source (output valid, green, status, input ready);
    modport sink   (input valid, green, status, output ready);
endinterface

// ===== src/fts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 112
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/fts_mod.sv =====
// Iterative remainder unit: one restoring step per cycle, TIME_BITS + 1 steps.
// Depends on fts_pkg for TIME_BITS and the step counter width.
`timescale 1ns / 1ps

module fts_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fts_pkg::TIME_BITS:0]   i_dividend,
    input  logic [fts_pkg::TIME_BITS-1:0] i_divisor,
    output logic                          o_done,
    output logic [fts_pkg::TIME_BITS-1:0] o_rem
);
    import fts_pkg::*;

    logic [TIME_BITS:0]   r_dvd, n_dvd;
    logic [TIME_BITS-1:0] r_dsr, n_dsr;
    logic [TIME_BITS-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [TIME_BITS:0]   trial;

    // The partial remainder stays below the divisor, so the trial value fits.
    always_comb begin
        trial  = {r_rem, r_dvd[TIME_BITS]};
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd = i_dividend;
            n_dsr = i_divisor;
            n_rem = '0;
            n_cnt = CNT_W'(TIME_BITS + 1);
        end else if (r_cnt != '0) begin
            n_dvd = {r_dvd[TIME_BITS-1:0], 1'b0};
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = TIME_BITS'(trial - {1'b0, r_dsr});
            end else begin
                n_rem = trial[TIME_BITS-1:0];
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== src/fixed_time_signal_controller.sv =====
// Load and unused actions need no reduction; a tick takes at most one modular reduction, a query up to
// two, a complement one per source window and a phase shift one per loaded window. Each
// reduction runs in the one shared remainder unit (17 restoring steps), and each table entry
// adds a read state and a setup state. One item is in work at a time: a new item is taken
// only once the result of the last is handed over. Synchronous active-low reset clears
// position, valid bits, configuration (60, free turns on), output; no clearing pass.
//
// Depends on fts_pkg, fts_in_if, fts_out_if, fts_ram and fts_mod.
`timescale 1ns / 1ps

module fixed_time_signal_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fts_pkg::CFG_W-1:0]     i_cfg_data,
    fts_in_if.sink                        i_in,
    fts_out_if.source                     o_out
);
    import fts_pkg::*;

    // Sequencer state and configuration.
    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_cycle_time;
    logic                 r_free;

    // The item in work, captured at acceptance.
    logic [ACT_W-1:0]     r_action;
    logic [STREET_W-1:0]  r_street;
    logic [DIR_W-1:0]     r_dir;
    logic [TIME_BITS-1:0] r_gt;
    logic [TIME_BITS-1:0] r_ph;
    logic [STREET_W-1:0]  r_src;
    logic [TIME_BITS-1:0] r_shift;

    // Block state: cycle position and one valid bit per window slot.
    logic [TIME_BITS-1:0] r_pos, n_pos;
    logic [SLOTS-1:0]     r_valid, n_valid;

    // Loop counters and working registers.
    logic [DIR_W-1:0]     r_cidx, n_cidx;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [TIME_BITS-1:0] r_wg, n_wg;
    logic [TIME_BITS-1:0] r_wp, n_wp;
    logic [TIME_BITS-1:0] r_ws, n_ws;

    // Result of the item in work and the output register.
    logic                 r_res_green, n_res_green;
    logic [STAT_W-1:0]    r_res_status, n_res_status;
    logic                 r_out_valid;
    logic                 r_out_green;
    logic [STAT_W-1:0]    r_out_status;
    logic                 out_load;

    // Shared remainder unit.
    logic                 mod_start;
    logic [TIME_BITS:0]   mod_dividend;
    logic                 mod_done;
    logic [TIME_BITS-1:0] mod_rem;

    // Window memory: green time in the upper half, phase in the lower half.
    logic                     ram_we;
    logic [SLOT_W-1:0]        ram_waddr;
    logic [2*TIME_BITS-1:0]   ram_wdata;
    logic [SLOT_W-1:0]        ram_raddr;
    logic [2*TIME_BITS-1:0]   ram_rdata;

    // Decoded helpers.
    logic                 in_accept;
    logic                 street_ok;
    logic                 src_ok;
    logic [NDIR-1:0]      st_v;
    logic [NDIR-1:0]      src_v;
    logic [DIR_W-1:0]     q_dir;
    logic                 q_hit;
    logic [TIME_BITS-1:0] rd_green;
    logic [TIME_BITS-1:0] rd_phase;
    logic [TIME_BITS-1:0] comp_green;
    logic [TIME_BITS:0]   comp_sum;
    logic                 shift_last;
    logic                 win_green;

    function automatic logic has_dir(input logic [NDIR-1:0] v, input logic [DIR_W-1:0] d);
        return (32'(d) < NDIR) ? v[d] : 1'b0;
    endfunction

    fts_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (r_cycle_time),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    fts_ram #(
        .WIDTH (2 * TIME_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_accept   = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.green = r_out_green;
    assign o_out.status = r_out_status;

    assign street_ok = (32'(r_street) < STREETS);
    assign src_ok    = (32'(r_src) < STREETS);

    // Valid bits of the addressed street and of the source street.
    always_comb begin
        for (int d = 0; d < NDIR; d++) begin
            st_v[d]  = r_valid[slot_of(r_street, DIR_W'(d))];
            src_v[d] = r_valid[slot_of(r_src, DIR_W'(d))];
        end
    end

    // Direction fallback of a query: the "any" window first, then the combined
    // directions (for a U-turn, left first) that cover the asked one.
    always_comb begin
        q_dir = r_dir;
        if (!has_dir(st_v, r_dir)) begin
            if (st_v[DIR_ANY]) begin
                q_dir = DIR_ANY;
            end else begin
                case (r_dir)
                    DIR_RIGHT: begin
                        if (st_v[DIR_RIGHT_STRAIGHT]) q_dir = DIR_RIGHT_STRAIGHT;
                    end
                    DIR_LEFT: begin
                        if (st_v[DIR_LEFT_STRAIGHT]) q_dir = DIR_LEFT_STRAIGHT;
                    end
                    DIR_STRAIGHT: begin
                        if (st_v[DIR_RIGHT_STRAIGHT]) q_dir = DIR_RIGHT_STRAIGHT;
                        else if (st_v[DIR_LEFT_STRAIGHT]) q_dir = DIR_LEFT_STRAIGHT;
                    end
                    DIR_UTURN: begin
                        if (st_v[DIR_LEFT]) q_dir = DIR_LEFT;
                        else if (st_v[DIR_LEFT_STRAIGHT]) q_dir = DIR_LEFT_STRAIGHT;
                    end
                    default: begin
                    end
                endcase
            end
        end
        q_hit = has_dir(st_v, q_dir);
    end

    assign rd_green = ram_rdata[2*TIME_BITS-1:TIME_BITS];
    assign rd_phase = ram_rdata[TIME_BITS-1:0];

    // Complementary window: green is the rest of the cycle (zero when the source
    // green is longer than the cycle), and it starts at the source phase plus that green.
    assign comp_green = (rd_green < r_cycle_time) ? (r_cycle_time - rd_green) : '0;
    assign comp_sum   = {1'b0, rd_phase} + {1'b0, comp_green};

    assign shift_last = (r_slot == SLOT_W'(SLOTS - 1));

    // Window test with start in r_ws and end from the remainder unit; a window
    // that wraps past the cycle end is green outside the gap.
    always_comb begin
        if (r_ws < mod_rem) begin
            win_green = (r_pos >= r_ws) && (r_pos < mod_rem);
        end else begin
            win_green = (r_pos >= r_ws) || (r_pos < mod_rem);
        end
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_valid      = r_valid;
        n_cidx       = r_cidx;
        n_slot       = r_slot;
        n_wg         = r_wg;
        n_wp         = r_wp;
        n_ws         = r_ws;
        n_res_green  = r_res_green;
        n_res_status = r_res_status;
        mod_start    = 1'b0;
        mod_dividend = '0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        out_load     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                n_res_green  = 1'b0;
                n_res_status = STAT_OK;
                n_state      = ST_FINISH;
                case (r_action)
                    ACT_TICK: begin
                        if (r_cycle_time == '0) begin
                            n_pos = '0;
                        end else begin
                            mod_start    = 1'b1;
                            mod_dividend = {1'b0, r_pos} + 1'b1;
                            n_state      = ST_TICK_WAIT;
                        end
                    end
                    ACT_LOAD: begin
                        // An existing window stays as it is.
                        if (!street_ok) begin
                            n_res_status = STAT_UNKNOWN_STREET;
                        end else if (r_gt > r_cycle_time) begin
                            n_res_status = STAT_GREEN_TOO_LONG;
                        end else if (!(r_ph < r_cycle_time)) begin
                            n_res_status = STAT_PHASE_RANGE;
                        end else if ((32'(r_dir) < NDIR) &&
                                     !r_valid[slot_of(r_street, r_dir)]) begin
                            n_valid[slot_of(r_street, r_dir)] = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = slot_of(r_street, r_dir);
                            ram_wdata = {r_gt, r_ph};
                        end
                    end
                    ACT_QUERY: begin
                        if (!street_ok || (st_v == '0)) begin
                            n_res_status = STAT_UNKNOWN_STREET;
                        end else if (!q_hit) begin
                            n_res_green = r_free;
                        end else begin
                            ram_raddr = slot_of(r_street, q_dir);
                            n_state   = ST_Q_START;
                        end
                    end
                    ACT_COMPLEMENT: begin
                        if (!street_ok || !src_ok) begin
                            n_res_status = STAT_UNKNOWN_STREET;
                        end else if (st_v != '0) begin
                            n_res_status = STAT_STREET_BUSY;
                        end else if (src_v == '0) begin
                            n_res_status = STAT_SOURCE_EMPTY;
                        end else begin
                            n_cidx  = '0;
                            n_state = ST_C_READ;
                        end
                    end
                    ACT_SHIFT: begin
                        if (r_cycle_time != '0) begin
                            n_slot  = '0;
                            n_state = ST_S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_TICK_WAIT: begin
                if (mod_done) begin
                    n_pos   = mod_rem;
                    n_state = ST_FINISH;
                end
            end

            ST_Q_START: begin
                // A zero green time or a zero cycle never shows green.
                if ((rd_green == '0) || (r_cycle_time == '0)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_wg         = rd_green;
                    n_wp         = rd_phase;
                    mod_start    = 1'b1;
                    mod_dividend = {1'b0, rd_phase};
                    n_state      = ST_Q_WAIT_S;
                end
            end

            ST_Q_WAIT_S: begin
                if (mod_done) begin
                    n_ws         = mod_rem;
                    mod_start    = 1'b1;
                    mod_dividend = {1'b0, r_wp} + {1'b0, r_wg};
                    n_state      = ST_Q_WAIT_E;
                end
            end

            ST_Q_WAIT_E: begin
                if (mod_done) begin
                    n_res_green = win_green;
                    n_state     = ST_FINISH;
                end
            end

            ST_C_READ: begin
                if (32'(r_cidx) >= NDIR) begin
                    n_state = ST_FINISH;
                end else if (src_v[r_cidx]) begin
                    ram_raddr = slot_of(r_src, r_cidx);
                    n_state   = ST_C_CALC;
                end else begin
                    n_cidx = r_cidx + 1'b1;
                end
            end

            ST_C_CALC: begin
                if (r_cycle_time == '0) begin
                    // No reduction with a zero cycle: the sum is kept as it is.
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(r_street, r_cidx);
                    ram_wdata = {comp_green, comp_sum[TIME_BITS-1:0]};
                    n_valid[slot_of(r_street, r_cidx)] = 1'b1;
                    n_cidx    = r_cidx + 1'b1;
                    n_state   = ST_C_READ;
                end else begin
                    n_wg         = comp_green;
                    mod_start    = 1'b1;
                    mod_dividend = comp_sum;
                    n_state      = ST_C_WAIT;
                end
            end

            ST_C_WAIT: begin
                if (mod_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(r_street, r_cidx);
                    ram_wdata = {r_wg, mod_rem};
                    n_valid[slot_of(r_street, r_cidx)] = 1'b1;
                    n_cidx    = r_cidx + 1'b1;
                    n_state   = ST_C_READ;
                end
            end

            ST_S_READ: begin
                if (r_valid[r_slot]) begin
                    ram_raddr = r_slot;
                    n_state   = ST_S_CALC;
                end else if (shift_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end

            ST_S_CALC: begin
                n_wg         = rd_green;
                mod_start    = 1'b1;
                mod_dividend = {1'b0, r_shift} + {1'b0, rd_phase};
                n_state      = ST_S_WAIT;
            end

            ST_S_WAIT: begin
                if (mod_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_slot;
                    ram_wdata = {r_wg, mod_rem};
                    if (shift_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = ST_S_READ;
                    end
                end
            end

            ST_FINISH: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_valid      <= '0;
            r_cycle_time <= CYCLE_TIME_RESET;
            r_free       <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CYCLE_TIME: r_cycle_time <= i_cfg_data;
                    CFG_FREE_TURNS: r_free       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_in.action;
            r_street <= i_in.street;
            r_dir    <= i_in.direction;
            r_gt     <= i_in.green_time;
            r_ph     <= i_in.phase;
            r_src    <= i_in.source_street;
            r_shift  <= i_in.phase_shift;
        end
        r_cidx       <= n_cidx;
        r_slot       <= n_slot;
        r_wg         <= n_wg;
        r_wp         <= n_wp;
        r_ws         <= n_ws;
        r_res_green  <= n_res_green;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_green  <= r_res_green;
            r_out_status <= r_res_status;
        end
    end
endmodule

// ===== src/fts_checker.sv =====
// Port-level assertions for the fixed-time signal controller, bound to its top level.
// Depends on fts_pkg for the status codes.
`timescale 1ns / 1ps

module fts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_green,
    input logic [fts_pkg::STAT_W-1:0] i_out_status
);
    import fts_pkg::*;

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item valid right after reset");

    // One item at a time: the block stops taking items once one is accepted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted while another is in work");

    // Only defined status codes leave the block.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= STAT_UNKNOWN_STREET))
        else $error("undefined status code");

    // A green answer comes only with an ok status.
    a_green_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_green) |-> (i_out_status == STAT_OK))
        else $error("green answer with an error status");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_green) && $stable(i_out_status)))
        else $error("stalled result item changed");
endmodule

bind fixed_time_signal_controller fts_checker u_fts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_green  (o_out.green),
    .i_out_status (o_out.status)
);
